// ===== hdl/sdr_pkg.sv =====
// ----------------------------------------------------------------------------
// sdr_pkg
// Shared constants and codes for the segmented delivery retry controller.
// ----------------------------------------------------------------------------
package sdr_pkg;

    localparam int ArgOverhead = 64;
    localparam int MaxSegments = 16;
    localparam int RetrySlots  = 4;

    localparam logic [16:0] DelayMin     = 17'(3 * 60);
    localparam logic [16:0] DelayMax     = 17'(4 * 60 * 60);
    localparam logic [16:0] DelayDefault = 17'(10 * 60);

    localparam logic [1:0] OP_DELIVER = 2'd0;
    localparam logic [1:0] OP_RESULT  = 2'd1;
    localparam logic [1:0] OP_ERROR   = 2'd2;
    localparam logic [1:0] OP_FAILURE = 2'd3;

    localparam logic [2:0] ACT_SEND       = 3'd0;
    localparam logic [2:0] ACT_RESEND     = 3'd1;
    localparam logic [2:0] ACT_DELIVERED  = 3'd2;
    localparam logic [2:0] ACT_RESPOOL    = 3'd3;
    localparam logic [2:0] ACT_NDR        = 3'd4;
    localparam logic [2:0] ACT_UNEXPECTED = 3'd5;

    localparam logic [2:0] REG_MAX_SINGLE  = 3'd0;
    localparam logic [2:0] REG_MIN_STREAM  = 3'd1;
    localparam logic [2:0] REG_MAX_RETRIES = 3'd2;
    localparam logic [2:0] REG_SLOTS       = 3'd3;
    localparam logic [2:0] REG_DELAY0      = 3'd4;
    localparam logic [2:0] REG_DELAY1      = 3'd5;
    localparam logic [2:0] REG_DELAY2      = 3'd6;
    localparam logic [2:0] REG_DELAY3      = 3'd7;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } t_div_ctl;

endpackage

// ===== hdl/segmented_delivery_retry_fsm_core.sv =====
// ----------------------------------------------------------------------------
// segmented_delivery_retry_fsm_core
// Delivery event controller: mode pick, segmentation, retry and respool.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_valid/o_stall carries one event transaction. Output
//   channel o_valid/i_stall carries one result transaction per event.
//   Config channel i_cfg_valid/o_cfg_ready writes register i_cfg_index;
//   it is always ready.
// Sequencing: an accepted event is evaluated in S_EVAL, which registers
//   its result. A deliver request that needs segmentation instead runs
//   the bit-serial divider in S_DIV and registers its result in S_SEG;
//   one whose segment size is zero goes from S_EVAL straight to S_SEG
//   and respools.
// Flow: one event in work at a time; the next event is accepted only
//   after the result is taken.
// Reset: synchronous active low; registers take their default values and
//   the controller is idle.
// Stall: a result waits in the output register while i_stall is high; the
//   next event is taken once that register is free.
// ----------------------------------------------------------------------------
module segmented_delivery_retry_fsm_core
    import sdr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_operation,
    input  logic [23:0] i_content_length,
    input  logic [7:0]  i_version_major,
    input  logic [7:0]  i_version_minor,
    input  logic        i_efficient_mode,
    input  logic [7:0]  i_recipient_failures,
    input  logic        i_error_is_resource,
    input  logic [7:0]  i_error_code,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_action,
    output logic [1:0]  o_delivery_mode,
    output logic        o_segmented,
    output logic        o_first_segment,
    output logic [31:0] o_sequence_id,
    output logic [7:0]  o_segment_number,
    output logic [7:0]  o_segment_count,
    output logic [23:0] o_segment_bytes,
    output logic [16:0] o_retry_delay,
    output logic [7:0]  o_error_out,
    output logic        o_large_warning,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);

    typedef enum logic [1:0] {S_IDLE, S_EVAL, S_DIV, S_SEG} t_state;

    t_state      r_state;
    logic [15:0] r_max_single;
    logic [23:0] r_min_stream;
    logic [7:0]  r_max_retries;
    logic [2:0]  r_slots;
    logic [16:0] r_delay [4];

    logic        r_phase, r_all_sent, r_is_seg;
    logic [31:0] r_seq;
    logic [7:0]  r_next_seg, r_last_seg, r_retry, r_fail;
    logic [23:0] r_left;
    logic [1:0]  r_mode;

    logic [1:0]  r_op;
    logic [23:0] r_content;
    logic [7:0]  r_vmaj, r_vmin, r_rfail, r_ecode;
    logic        r_eff, r_eres;

    logic        r_ov;
    logic [2:0]  r_act;
    logic [1:0]  r_omode;
    logic        r_oseg, r_ofirst, r_owarn;
    logic [31:0] r_oseq;
    logic [7:0]  r_onum, r_ocnt, r_oerr;
    logic [23:0] r_obytes;
    logic [16:0] r_odelay;

    t_div_ctl    w_div;
    logic        w_div_start;
    logic [23:0] w_ceil;
    logic [15:0] w_seg;
    logic [24:0] w_len;
    logic [2:0]  w_slots;
    logic [7:0]  w_idx;
    logic [16:0] w_d, w_delay;
    logic [7:0]  w_retry_inc;
    logic [23:0] w_bytes;
    logic [1:0]  w_mode;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = (r_state != S_IDLE) || r_ov;
    assign w_seg  = (r_max_single > 16'(ArgOverhead)) ? r_max_single - 16'(ArgOverhead) : '0;
    assign w_len  = {1'b0, r_content} + 25'(ArgOverhead);
    assign w_div_start = (r_state == S_EVAL) && !r_phase && (r_op == OP_DELIVER)
        && (w_len > {9'd0, r_max_single}) && (w_len < {1'b0, r_min_stream})
        && (w_seg != '0);

    always_comb begin
        w_slots = (r_slots == 3'd0) ? 3'd1 : r_slots;
        if (w_slots > 3'(RetrySlots)) begin
            w_slots = 3'(RetrySlots);
        end
        w_idx = (r_fail < {5'd0, w_slots}) ? r_fail : {5'd0, w_slots - 3'd1};
        w_d   = r_delay[w_idx[1:0]];
        w_delay = (w_d < DelayMin || w_d > DelayMax) ? DelayDefault : w_d;
        w_retry_inc = (r_retry == 8'hFF) ? r_retry : r_retry + 8'd1;
        if (r_next_seg >= r_last_seg || w_seg == '0 || {8'd0, w_seg} > r_left) begin
            w_bytes = r_left;
        end else begin
            w_bytes = {8'd0, w_seg};
        end
        if (r_vmaj == 8'd1 && r_vmin == 8'd0) begin
            w_mode = 2'd0;
        end else if (r_eff) begin
            w_mode = 2'd1;
        end else begin
            w_mode = 2'd2;
        end
    end

    sdr_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_content),
        .i_divisor  (w_seg),
        .o_ctl      (w_div),
        .o_ceil     (w_ceil)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_ov          <= 1'b0;
            r_max_single  <= 16'd1500;
            r_min_stream  <= 24'd65536;
            r_max_retries <= 8'd3;
            r_slots       <= 3'd4;
            r_delay[0]    <= 17'd600;
            r_delay[1]    <= 17'd1200;
            r_delay[2]    <= 17'd3600;
            r_delay[3]    <= 17'd7200;
            r_phase       <= 1'b0;
            r_all_sent    <= 1'b0;
            r_is_seg      <= 1'b0;
            r_seq         <= '0;
            r_next_seg    <= '0;
            r_last_seg    <= '0;
            r_left        <= '0;
            r_retry       <= '0;
            r_fail        <= '0;
            r_mode        <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_MAX_SINGLE:  r_max_single  <= i_cfg_data[15:0];
                    REG_MIN_STREAM:  r_min_stream  <= i_cfg_data;
                    REG_MAX_RETRIES: r_max_retries <= i_cfg_data[7:0];
                    REG_SLOTS:       r_slots       <= i_cfg_data[2:0];
                    REG_DELAY0:      r_delay[0]    <= i_cfg_data[16:0];
                    REG_DELAY1:      r_delay[1]    <= i_cfg_data[16:0];
                    REG_DELAY2:      r_delay[2]    <= i_cfg_data[16:0];
                    REG_DELAY3:      r_delay[3]    <= i_cfg_data[16:0];
                    default: ;
                endcase
            end
            if (r_ov && !i_stall) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && !o_stall) begin
                        r_op      <= i_operation;
                        r_content <= i_content_length;
                        r_vmaj    <= i_version_major;
                        r_vmin    <= i_version_minor;
                        r_eff     <= i_efficient_mode;
                        r_rfail   <= i_recipient_failures;
                        r_eres    <= i_error_is_resource;
                        r_ecode   <= i_error_code;
                        r_state   <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    r_act    <= ACT_UNEXPECTED;
                    r_omode  <= '0;
                    r_oseg   <= 1'b0;
                    r_ofirst <= 1'b0;
                    r_oseq   <= '0;
                    r_onum   <= '0;
                    r_ocnt   <= '0;
                    r_obytes <= '0;
                    r_odelay <= '0;
                    r_oerr   <= '0;
                    r_owarn  <= 1'b0;
                    r_state  <= S_IDLE;
                    r_ov     <= 1'b1;
                    if (!r_phase) begin
                        if (r_op == OP_DELIVER) begin
                            r_mode   <= w_mode;
                            r_fail   <= r_rfail;
                            r_retry  <= '0;
                            r_phase  <= 1'b1;
                            r_omode  <= w_mode;
                            r_owarn  <= w_len >= {1'b0, r_min_stream};
                            if (w_len > {9'd0, r_max_single}
                                    && w_len < {1'b0, r_min_stream}) begin
                                r_seq    <= r_seq + 32'd1;
                                r_is_seg <= 1'b1;
                                if (w_seg == '0) begin
                                    r_fail   <= r_rfail;
                                    r_state  <= S_SEG;
                                    r_ov     <= 1'b0;
                                end else begin
                                    r_state <= S_DIV;
                                    r_ov    <= 1'b0;
                                end
                            end else begin
                                r_is_seg   <= 1'b0;
                                r_left     <= '0;
                                r_next_seg <= 8'd1;
                                r_last_seg <= '0;
                                r_all_sent <= 1'b1;
                                r_act      <= ACT_SEND;
                                r_ocnt     <= 8'd1;
                                r_obytes   <= r_content;
                            end
                        end
                    end else begin
                        r_omode <= r_mode;
                        r_oseg  <= r_is_seg;
                        r_oseq  <= r_is_seg ? r_seq : '0;
                        unique case (r_op)
                            OP_RESULT: begin
                                if (r_all_sent) begin
                                    r_act   <= ACT_DELIVERED;
                                    r_phase <= 1'b0;
                                end else begin
                                    r_act      <= ACT_SEND;
                                    r_onum     <= r_next_seg;
                                    r_ocnt     <= r_last_seg + 8'd1;
                                    r_obytes   <= w_bytes;
                                    r_left     <= r_left - w_bytes;
                                    r_next_seg <= r_next_seg + 8'd1;
                                    if (r_next_seg + 8'd1 > r_last_seg
                                            || r_next_seg == 8'hFF) begin
                                        r_all_sent <= 1'b1;
                                    end
                                end
                            end
                            OP_ERROR: begin
                                r_phase <= 1'b0;
                                if (r_eres) begin
                                    r_act    <= ACT_RESPOOL;
                                    r_odelay <= w_delay;
                                end else begin
                                    r_act  <= ACT_NDR;
                                    r_oerr <= r_ecode;
                                end
                            end
                            OP_FAILURE: begin
                                r_retry <= w_retry_inc;
                                if (w_retry_inc >= r_max_retries) begin
                                    r_act    <= ACT_RESPOOL;
                                    r_odelay <= w_delay;
                                    r_phase  <= 1'b0;
                                end else begin
                                    r_act  <= ACT_RESEND;
                                    r_onum <= r_next_seg - 8'd1;
                                    r_ocnt <= r_last_seg + 8'd1;
                                end
                            end
                            default: begin
                                r_omode <= '0;
                                r_oseg  <= 1'b0;
                                r_oseq  <= '0;
                                r_phase <= 1'b0;
                            end
                        endcase
                    end
                end
                S_DIV: begin
                    if (w_div.done) begin
                        r_state <= S_SEG;
                    end
                end
                S_SEG: begin
                    r_ov     <= 1'b1;
                    r_state  <= S_IDLE;
                    r_oseg   <= 1'b1;
                    r_oseq   <= r_seq;
                    if (w_seg == '0 || w_ceil > 24'(MaxSegments) || w_ceil > 24'd255) begin
                        r_act    <= ACT_RESPOOL;
                        r_odelay <= w_delay;
                        r_owarn  <= 1'b0;
                        r_phase  <= 1'b0;
                    end else begin
                        r_act      <= ACT_SEND;
                        r_ofirst   <= 1'b1;
                        r_ocnt     <= (w_ceil == '0) ? 8'd1 : w_ceil[7:0];
                        r_obytes   <= (r_content < {8'd0, w_seg}) ? r_content : {8'd0, w_seg};
                        r_left     <= (r_content < {8'd0, w_seg}) ? '0
                                      : r_content - {8'd0, w_seg};
                        r_next_seg <= 8'd1;
                        r_last_seg <= (w_ceil == '0) ? 8'd0 : w_ceil[7:0] - 8'd1;
                        r_all_sent <= (w_ceil <= 24'd1);
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid          = r_ov;
    assign o_action         = r_act;
    assign o_delivery_mode  = r_omode;
    assign o_segmented      = r_oseg;
    assign o_first_segment  = r_ofirst;
    assign o_sequence_id    = r_oseq;
    assign o_segment_number = r_onum;
    assign o_segment_count  = r_ocnt;
    assign o_segment_bytes  = r_obytes;
    assign o_retry_delay    = r_odelay;
    assign o_error_out      = r_oerr;
    assign o_large_warning  = r_owarn;

`ifndef ASSERT_OFF
    a_busy_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> !r_ov) else $error("result during divide");
    a_div_only_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div.busy |-> (r_state == S_DIV)) else $error("divider busy outside divide");
    a_ov_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && i_stall) |=> (r_ov && $stable(r_act))) else $error("result lost");
`endif

endmodule

// ===== hdl/sdr_divider.sv =====
// ----------------------------------------------------------------------------
// sdr_divider
// Bit-serial restoring divider, one quotient bit per cycle, giving the
// ceiling of content over segment size.
// ----------------------------------------------------------------------------
module sdr_divider
    import sdr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [23:0] i_dividend,
    input  logic [15:0] i_divisor,
    output t_div_ctl    o_ctl,
    output logic [23:0] o_ceil
);

    logic [23:0] r_quo, n_quo;
    logic [24:0] r_rem, n_rem;
    logic [4:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [15:0] r_div;
    logic [24:0] w_trial;

    always_comb begin
        w_trial = {r_rem[23:0], r_quo[23]};
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_busy  = r_busy;
        n_done  = 1'b0;
        if (i_start) begin
            n_quo  = i_dividend;
            n_rem  = '0;
            n_cnt  = 5'd0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_trial >= {9'd0, r_div}) begin
                n_rem = w_trial - {9'd0, r_div};
                n_quo = {r_quo[22:0], 1'b1};
            end else begin
                n_rem = w_trial;
                n_quo = {r_quo[22:0], 1'b0};
            end
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'd23) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        if (i_start) begin
            r_div <= i_divisor;
        end
    end

    assign o_ctl  = '{start: i_start, busy: r_busy, done: r_done};
    assign o_ceil = r_quo + {23'd0, (r_rem != '0)};

endmodule
